/* src/assert_macros.svh */
// Assertion helpers shared by the packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, outside reset.
`define HSBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsbp assertion failed");

// Check that a condition never holds.
`define HSBP_ASSERT_NEVER(lbl, cond) \
  `HSBP_ASSERT(lbl, !(cond))

`endif

/* src/hsbp_pkg.sv */
package hsbp_pkg;

  localparam int unsigned CodeW     = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SymW      = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned BitIdxW   = $clog2(ByteW);
  localparam int unsigned AccW      = CodeW + ByteW - 1;
  localparam int unsigned CntW      = $clog2(AccW + 1);
  localparam int unsigned InDataW   = 48;
  localparam int unsigned InUserW   = OpW;
  localparam int unsigned OutDataW  = ByteW;
  localparam int unsigned OutUserW  = 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [OpW-1:0] OpLoad   = 2'd0;
  localparam logic [OpW-1:0] OpEncode = 2'd1;
  localparam logic [OpW-1:0] OpFlush  = 2'd2;

  localparam logic [SymW-1:0] NewlineByte    = 8'd10;
  localparam logic [SymW-1:0] FirstPrintable = 8'd32;
  localparam logic [SymW-1:0] LastPrintable  = 8'd126;
  localparam logic [SymW-1:0] NewlineEntry   = 8'd96;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_BAD,
    CMD_FLUSH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [CodeW-1:0]      code;
    logic [LenW-1:0]       len;
  } cmd_t;

endpackage

/* src/hsbp_front.sv */
module hsbp_front #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 97
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hsbp_pkg::InDataW-1:0]        s_axis_tdata,
  input  logic [hsbp_pkg::InUserW-1:0]        s_axis_tuser,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output hsbp_pkg::cmd_t                      cmd_o
);

  localparam int unsigned IdxW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned EntryW = hsbp_pkg::CodeW + hsbp_pkg::LenW;
  localparam int unsigned LenCap = (MAX_CODE_LEN < hsbp_pkg::CodeW) ? MAX_CODE_LEN
                                                                     : hsbp_pkg::CodeW;
  localparam logic [hsbp_pkg::SymW:0]     NumSymV = (hsbp_pkg::SymW + 1)'(NUM_SYMBOLS);
  localparam logic [hsbp_pkg::LenW-1:0]   LenCapV = hsbp_pkg::LenW'(LenCap);

  logic [hsbp_pkg::OpW-1:0]   op;
  logic [hsbp_pkg::SymW-1:0]  sym;
  logic [hsbp_pkg::CodeW-1:0] code;
  logic [hsbp_pkg::LenW-1:0]  len;

  logic                       accept;
  logic                       map_ok;
  logic                       rd_ok;
  logic                       load_ok;
  logic [hsbp_pkg::SymW-1:0]  map_idx;
  logic [hsbp_pkg::LenW-1:0]  len_sat;
  logic [hsbp_pkg::CodeW:0]   mask_w;
  logic [hsbp_pkg::CodeW-1:0] code_masked;

  logic [EntryW-1:0]          table_mem [NUM_SYMBOLS];
  logic [EntryW-1:0]          rdata_q;
  logic [NUM_SYMBOLS-1:0]     valid_q;

  logic                       s1_valid_q, s1_valid_d;
  hsbp_pkg::cmd_kind_e        s1_kind_q, s1_kind_d;
  logic                       s1_hit_q, s1_hit_d;
  logic [hsbp_pkg::LenW-1:0]  rd_len;

  assign op   = s_axis_tuser;
  assign sym  = s_axis_tdata[7:0];
  assign code = s_axis_tdata[39:8];
  assign len  = s_axis_tdata[45:40];

  assign s_axis_tready = !s1_valid_q || cmd_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    map_ok  = 1'b1;
    map_idx = '0;
    if (sym == hsbp_pkg::NewlineByte) begin
      map_idx = hsbp_pkg::NewlineEntry;
    end else if (sym >= hsbp_pkg::FirstPrintable && sym <= hsbp_pkg::LastPrintable) begin
      map_idx = sym - hsbp_pkg::FirstPrintable;
    end else begin
      map_ok = 1'b0;
    end
  end

  assign rd_ok   = map_ok && ({1'b0, map_idx} < NumSymV);
  assign load_ok = {1'b0, sym} < NumSymV;

  assign len_sat     = (len > LenCapV) ? LenCapV : len;
  assign mask_w      = ((hsbp_pkg::CodeW + 1)'(1) << len_sat) - (hsbp_pkg::CodeW + 1)'(1);
  assign code_masked = code & mask_w[hsbp_pkg::CodeW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && op == hsbp_pkg::OpLoad && load_ok) begin
      table_mem[sym[IdxW-1:0]] <= {code_masked, len_sat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op == hsbp_pkg::OpEncode && rd_ok) begin
      rdata_q <= table_mem[map_idx[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept && op == hsbp_pkg::OpLoad && load_ok) begin
      valid_q[sym[IdxW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q && !cmd_ready_i;
    s1_kind_d  = s1_kind_q;
    s1_hit_d   = s1_hit_q;
    if (accept) begin
      unique case (op)
        hsbp_pkg::OpEncode: begin
          s1_valid_d = 1'b1;
          s1_kind_d  = rd_ok ? hsbp_pkg::CMD_ENCODE : hsbp_pkg::CMD_BAD;
          s1_hit_d   = rd_ok && valid_q[map_idx[IdxW-1:0]];
        end
        hsbp_pkg::OpFlush: begin
          s1_valid_d = 1'b1;
          s1_kind_d  = hsbp_pkg::CMD_FLUSH;
          s1_hit_d   = 1'b0;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= hsbp_pkg::CMD_FLUSH;
      s1_hit_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_kind_q  <= s1_kind_d;
      s1_hit_q   <= s1_hit_d;
    end
  end

  assign rd_len      = rdata_q[hsbp_pkg::LenW-1:0];
  assign cmd_valid_o = s1_valid_q;

  always_comb begin
    cmd_o.kind = s1_kind_q;
    cmd_o.code = rdata_q[EntryW-1:hsbp_pkg::LenW];
    cmd_o.len  = rd_len;
    if (s1_kind_q == hsbp_pkg::CMD_ENCODE && (!s1_hit_q || rd_len == '0)) begin
      cmd_o.kind = hsbp_pkg::CMD_BAD;
    end
  end

endmodule

/* src/hsbp_fifo.sv */
`include "assert_macros.svh"

module hsbp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hsbp_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hsbp_pkg::cmd_t  pop_cmd_o
);

  hsbp_pkg::cmd_t                 entry_q [hsbp_pkg::QueueDepth];
  logic [hsbp_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [hsbp_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [hsbp_pkg::QCntW-1:0]     count_q, count_d;
  logic                           push;
  logic                           pop;

  assign push_ready_o = count_q != hsbp_pkg::QCntW'(hsbp_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == hsbp_pkg::QPtrW'(hsbp_pkg::QueueDepth - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == hsbp_pkg::QPtrW'(hsbp_pkg::QueueDepth - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `HSBP_ASSERT_NEVER(a_count_bound, count_q > hsbp_pkg::QCntW'(hsbp_pkg::QueueDepth))
  `HSBP_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1)

endmodule

/* src/hsbp_back.sv */
`include "assert_macros.svh"

module hsbp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  hsbp_pkg::cmd_t                   cmd_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hsbp_pkg::OutDataW-1:0]    m_axis_tdata,   // out_byte
  output logic                             m_axis_tlast,
  output logic [hsbp_pkg::OutUserW-1:0]    m_axis_tuser    // bad_symbol
);

  logic [hsbp_pkg::AccW-1:0]   acc_q, acc_d;
  logic [hsbp_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [hsbp_pkg::ByteW-1:0]  out_byte_q, out_byte_d;
  logic                        out_last_q, out_last_d;
  logic                        out_bad_q, out_bad_d;
  logic                        out_free;
  logic                        draining;
  logic                        take;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign draining    = cnt_q >= hsbp_pkg::CntW'(hsbp_pkg::ByteW);
  assign cmd_ready_o = !draining && out_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    if (draining) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_byte_d  = acc_q[hsbp_pkg::ByteW-1:0];
        out_last_d  = cnt_q < hsbp_pkg::CntW'(2 * hsbp_pkg::ByteW);
        out_bad_d   = 1'b0;
        acc_d       = acc_q >> hsbp_pkg::ByteW;
        cnt_d       = cnt_q - hsbp_pkg::CntW'(hsbp_pkg::ByteW);
      end
    end else if (take) begin
      unique case (cmd_i.kind)
        hsbp_pkg::CMD_ENCODE: begin
          acc_d = hsbp_pkg::AccW'(acc_q[hsbp_pkg::ByteW-2:0])
                | (hsbp_pkg::AccW'(cmd_i.code) << cnt_q[hsbp_pkg::BitIdxW-1:0]);
          cnt_d = cnt_q + hsbp_pkg::CntW'(cmd_i.len);
        end
        hsbp_pkg::CMD_BAD: begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
        end
        hsbp_pkg::CMD_FLUSH: begin
          if (cnt_q != '0) begin
            out_valid_d = 1'b1;
            out_byte_d  = acc_q[hsbp_pkg::ByteW-1:0];
            out_last_d  = 1'b1;
            out_bad_d   = 1'b0;
          end
          acc_d = '0;
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_bad_q;

  `HSBP_ASSERT(a_bad_empty, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tlast)
  `HSBP_ASSERT(a_drain_hold, draining && !out_free |=> $stable(acc_q) && $stable(cnt_q))

endmodule

/* src/huffman_symbol_bit_packer.sv */
// Huffman bit packer with a loadable code table of NUM_SYMBOLS entries (invalid at reset).
// Each input transaction loads a table entry, encodes one text byte or flushes the
// partial byte; the unused op is dropped. Code bits fill each output byte from bit 0 up.
// A load writes the table in the front end. An encode passes the registered table read
// and the command queue; the packer then merges the code, up to 32 bits, and emits each
// completed byte. The packer's one-byte-per-cycle output register, when m_axis_tready
// does not stall it, sets the sustained rate. A two-entry command queue lets loads and
// table reads run ahead while bytes drain; while a result waits in the output register
// the packer takes no new command, but new transactions still enter the queue.
module huffman_symbol_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 97
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // symbol[7:0], code_bits[39:8], code_length[45:40], zero pad
  input  logic [hsbp_pkg::InDataW-1:0]     s_axis_tdata,
  // op
  input  logic [hsbp_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_byte
  output logic [hsbp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast,
  // bad_symbol
  output logic [hsbp_pkg::OutUserW-1:0]    m_axis_tuser
);

  logic           f_valid;
  logic           f_ready;
  hsbp_pkg::cmd_t f_cmd;
  logic           b_valid;
  logic           b_ready;
  hsbp_pkg::cmd_t b_cmd;

  hsbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  hsbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  hsbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (b_valid),
    .cmd_ready_o   (b_ready),
    .cmd_i         (b_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sim/hsbp_pack_checker.sv */
`timescale 1ns / 100ps

module hsbp_pack_checker #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 97
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // symbol[7:0], code_bits[39:8], code_length[45:40], zero pad
  input  logic [hsbp_pkg::InDataW-1:0]     s_axis_tdata,
  // op
  input  logic [hsbp_pkg::InUserW-1:0]     s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_byte
  input  logic [hsbp_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             m_axis_tlast,
  // bad_symbol
  input  logic [hsbp_pkg::OutUserW-1:0]    m_axis_tuser,
  output int                               err_cnt_o,
  output int                               bytes_due_o,
  output int                               items_seen_o,
  output int                               bytes_seen_o,
  output int                               flagged_seen_o
);

  localparam int unsigned LenCap = (MAX_CODE_LEN < hsbp_pkg::CodeW) ? MAX_CODE_LEN
                                                                     : hsbp_pkg::CodeW;

  typedef struct packed {
    logic [hsbp_pkg::ByteW-1:0] data;
    logic                       last;
    logic                       bad;
  } packed_byte_t;

  packed_byte_t               bytes_due[$];
  packed_byte_t               want;
  logic [hsbp_pkg::CodeW-1:0] code_tbl[NUM_SYMBOLS];
  logic [hsbp_pkg::LenW-1:0]  len_tbl[NUM_SYMBOLS];
  logic [6:0]                 held_bits;
  logic [2:0]                 held_cnt;
  int                         err_n;
  int                         items_n;
  int                         bytes_n;
  int                         flagged_n;

  task automatic pack_code(input logic [hsbp_pkg::OpW-1:0] op,
                           input logic [hsbp_pkg::SymW-1:0] sym,
                           input logic [hsbp_pkg::CodeW-1:0] code,
                           input logic [hsbp_pkg::LenW-1:0] len);
    logic [hsbp_pkg::AccW-1:0] acc;
    int unsigned               idx;
    int unsigned               clen;
    int unsigned               total;
    bit                        ok;
    case (op)
      hsbp_pkg::OpLoad: begin
        if (sym < NUM_SYMBOLS) begin
          clen = (len > LenCap) ? LenCap : len;
          code_tbl[sym] = code & hsbp_pkg::CodeW'((64'd1 << clen) - 64'd1);
          len_tbl[sym]  = hsbp_pkg::LenW'(clen);
        end
      end
      hsbp_pkg::OpEncode: begin
        ok  = 1'b1;
        idx = 0;
        if (sym == hsbp_pkg::NewlineByte) begin
          idx = hsbp_pkg::NewlineEntry;
        end else if (sym >= hsbp_pkg::FirstPrintable && sym <= hsbp_pkg::LastPrintable) begin
          idx = sym - hsbp_pkg::FirstPrintable;
        end else begin
          ok = 1'b0;
        end
        if (ok && idx >= NUM_SYMBOLS) ok = 1'b0;
        if (ok && len_tbl[idx] == 0) ok = 1'b0;
        if (!ok) begin
          bytes_due.push_back('{data: '0, last: 1'b1, bad: 1'b1});
        end else begin
          clen  = len_tbl[idx];
          total = held_cnt + clen;
          acc   = hsbp_pkg::AccW'(held_bits)
                | (hsbp_pkg::AccW'(code_tbl[idx] & hsbp_pkg::CodeW'((64'd1 << clen) - 64'd1))
                   << held_cnt);
          while (total >= hsbp_pkg::ByteW) begin
            bytes_due.push_back('{data: acc[hsbp_pkg::ByteW-1:0],
                                  last: (total < 2 * hsbp_pkg::ByteW), bad: 1'b0});
            acc   = acc >> hsbp_pkg::ByteW;
            total = total - hsbp_pkg::ByteW;
          end
          held_bits = acc[6:0];
          held_cnt  = total[2:0];
        end
      end
      hsbp_pkg::OpFlush: begin
        if (held_cnt != 0) begin
          bytes_due.push_back('{data: {1'b0, held_bits}, last: 1'b1, bad: 1'b0});
          held_bits = '0;
          held_cnt  = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        code_tbl[i] = '0;
        len_tbl[i]  = '0;
      end
      held_bits = '0;
      held_cnt  = '0;
      bytes_due.delete();
      err_n     = 0;
      items_n   = 0;
      bytes_n   = 0;
      flagged_n = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_n++;
        if (m_axis_tuser[0]) flagged_n++;
        if (bytes_due.size() == 0) begin
          err_n++;
          $display("%0t: unexpected byte: expected none, actual data %02h last %0b bad %0b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        end else begin
          want = bytes_due.pop_front();
          if (m_axis_tdata !== want.data) begin
            err_n++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, m_axis_tdata);
          end
          if (m_axis_tlast !== want.last) begin
            err_n++;
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last, m_axis_tlast);
          end
          if (m_axis_tuser[0] !== want.bad) begin
            err_n++;
            $display("%0t: bad_symbol mismatch: expected %0b, actual %0b",
                     $time, want.bad, m_axis_tuser[0]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_n++;
        pack_code(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8], s_axis_tdata[45:40]);
      end
    end
    err_cnt_o      <= err_n;
    bytes_due_o    <= bytes_due.size();
    items_seen_o   <= items_n;
    bytes_seen_o   <= bytes_n;
    flagged_seen_o <= flagged_n;
  end

endmodule

/* sim/tb_huffman_symbol_bit_packer.sv */
`timescale 1ns / 100ps

module tb_huffman_symbol_bit_packer;

  localparam logic [hsbp_pkg::OpW-1:0] OpUnused   = 2'd3;
  localparam int                       CycleLimit = 200000;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hsbp_pkg::InDataW-1:0]    s_axis_tdata  = '0;
  logic [hsbp_pkg::InUserW-1:0]    s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hsbp_pkg::OutDataW-1:0]   m_axis_tdata;
  logic                            m_axis_tlast;
  logic [hsbp_pkg::OutUserW-1:0]   m_axis_tuser;

  int err_cnt;
  int bytes_due;
  int items_seen;
  int bytes_seen;
  int flagged_seen;
  int cycle_cnt = 0;
  bit calm      = 1'b0;

  huffman_symbol_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  hsbp_pack_checker u_pack_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .err_cnt_o      (err_cnt),
    .bytes_due_o    (bytes_due),
    .items_seen_o   (items_seen),
    .bytes_seen_o   (bytes_seen),
    .flagged_seen_o (flagged_seen)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    m_axis_tready <= calm || ($urandom_range(99) >= 15);
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input logic [hsbp_pkg::OpW-1:0] op,
                           input logic [hsbp_pkg::SymW-1:0] sym,
                           input logic [hsbp_pkg::CodeW-1:0] code,
                           input logic [hsbp_pkg::LenW-1:0] len);
    if (!calm && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, len, code, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [hsbp_pkg::LenW-1:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return hsbp_pkg::LenW'($urandom_range(33, 63));
    if (roll < 25) return hsbp_pkg::LenW'($urandom_range(13, 32));
    return hsbp_pkg::LenW'($urandom_range(1, 12));
  endfunction

  task automatic random_item();
    int unsigned roll;
    int unsigned slot;
    roll = $urandom_range(99);
    if (roll < 8) begin
      slot = ($urandom_range(99) < 90) ? $urandom_range(96) : $urandom_range(97, 255);
      send_item(hsbp_pkg::OpLoad, hsbp_pkg::SymW'(slot), $urandom, pick_len());
    end else if (roll < 70) begin
      slot = $urandom_range(95);
      send_item(hsbp_pkg::OpEncode,
                (slot == 95) ? hsbp_pkg::NewlineByte : hsbp_pkg::SymW'(slot + 32),
                $urandom, pick_len());
    end else if (roll < 80) begin
      send_item(hsbp_pkg::OpFlush, hsbp_pkg::SymW'($urandom), $urandom,
                hsbp_pkg::LenW'($urandom));
    end else if (roll < 96) begin
      send_item(hsbp_pkg::OpEncode, hsbp_pkg::SymW'($urandom_range(255)), $urandom,
                hsbp_pkg::LenW'($urandom));
    end else begin
      send_item(OpUnused, hsbp_pkg::SymW'($urandom), $urandom, hsbp_pkg::LenW'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(hsbp_pkg::OpEncode, "A", '0, '0);
    send_item(hsbp_pkg::OpEncode, 8'h00, '0, '0);
    send_item(hsbp_pkg::OpEncode, 8'hff, '0, '0);
    send_item(hsbp_pkg::OpEncode, 8'd31, '0, '0);
    send_item(hsbp_pkg::OpEncode, 8'd127, '0, '0);
    send_item(hsbp_pkg::OpEncode, 8'd9, '0, '0);
    send_item(hsbp_pkg::OpLoad, 8'd0, 32'hffff_ffff, 6'd32);
    send_item(hsbp_pkg::OpLoad, 8'd94, 32'h1234_5678, 6'd63);
    send_item(hsbp_pkg::OpLoad, hsbp_pkg::NewlineEntry, 32'h0000_0001, 6'd1);
    send_item(hsbp_pkg::OpLoad, 8'd33, 32'hffff_fffd, 6'd3);
    send_item(hsbp_pkg::OpLoad, 8'd97, 32'h0000_ffff, 6'd4);
    send_item(hsbp_pkg::OpLoad, 8'd255, 32'h0000_0000, 6'd1);
    send_item(OpUnused, "A", 32'hdead_beef, 6'd7);
    send_item(hsbp_pkg::OpFlush, 8'h00, '0, '0);
    send_item(hsbp_pkg::OpEncode, " ", '0, '0);
    send_item(hsbp_pkg::OpEncode, hsbp_pkg::NewlineByte, '0, '0);
    send_item(hsbp_pkg::OpEncode, "A", '0, '0);
    send_item(hsbp_pkg::OpEncode, "~", '0, '0);
    send_item(hsbp_pkg::OpFlush, 8'h00, '0, '0);
    send_item(hsbp_pkg::OpFlush, 8'h00, '0, '0);
    send_item(hsbp_pkg::OpLoad, 8'd33, 32'h0000_00ff, 6'd0);
    send_item(hsbp_pkg::OpEncode, "A", '0, '0);
    send_item(hsbp_pkg::OpEncode, hsbp_pkg::LastPrintable, '0, '0);
    send_item(hsbp_pkg::OpLoad, 8'd1, 32'h0000_007f, 6'd7);
    send_item(hsbp_pkg::OpEncode, "!", '0, '0);
    send_item(hsbp_pkg::OpEncode, "!", '0, '0);

    for (int i = 0; i < 97; i++) begin
      send_item(hsbp_pkg::OpLoad, hsbp_pkg::SymW'(i), $urandom, pick_len());
    end
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 150 && i < 230);
      random_item();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (bytes_due != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d input transactions (loads, encodes, flushes, unused op) and",
             items_seen);
    $display("%0d output bytes, %0d of them flagged as bad symbols.", bytes_seen, flagged_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
